// ===== sv/poly_voice_allocator_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the poly voice allocator
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef POLY_VOICE_ALLOCATOR_DEFINES_SVH
`define POLY_VOICE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// The expression must be true at every clock edge outside reset.
`define PVA_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("pva assertion failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define PVA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pva assertion failed");

// When the antecedent holds, the consequent holds in the next cycle.
`define PVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pva assertion failed");

`else

`define PVA_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define PVA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PVA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/pva_pkg.sv =====
// ---------------------------------------------------------------------------
// pva_pkg
// Shared types and constants of the poly voice allocator.
// ---------------------------------------------------------------------------
package pva_pkg;

  localparam int CMD_W      = 2;
  localparam int NOTE_W     = 7;
  localparam int LEVEL_W    = 9;
  localparam int FIN_W      = 4;
  localparam int OUT_IDX_W  = 4;
  localparam int MASK_W     = 16;
  localparam int OUT_CNT_W  = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Velocity of 1.0 in value/256 fixed point.
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 9'd256;

  // Register index of the steal mode register (byte address 4*index).
  localparam logic REG_STEAL_MODE = 1'b0;

  // Steal policies.
  localparam logic STEAL_OLDEST = 1'b0;
  localparam logic STEAL_QUIET  = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_NOTE_ON    = 2'd0,
    CMD_NOTE_OFF   = 2'd1,
    CMD_ALL_OFF    = 2'd2,
    CMD_VOICE_DONE = 2'd3
  } pva_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_UPDATE = 2'd2,
    ST_FLUSH  = 2'd3
  } pva_state_t;

  // Controls for the rewrite sweep, decided at the end of the scan sweep.
  typedef struct packed {
    logic write_note;   // note-on: the hit entry takes the new note
    logic finish_hit;   // voice finished: the hit entry goes inactive
    logic remove_en;    // an entry leaves the list, later entries move up
    logic clear_list;   // all notes off: the list is emptied
  } pva_upd_ctl_t;

endpackage

// ===== sv/pva_ram.sv =====
// ---------------------------------------------------------------------------
// pva_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ---------------------------------------------------------------------------
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pva_scan.sv =====
// ---------------------------------------------------------------------------
// pva_scan
// Accumulates the voice search over one read sweep and derives the decision.
// ---------------------------------------------------------------------------
module pva_scan #(
  parameter int NUM_VOICES = 16
) (
  input  logic                             clk,
  input  logic                             clr,
  input  logic                             en,
  input  logic [$clog2(NUM_VOICES)-1:0]    idx,
  input  logic                             e_act,
  input  logic [pva_pkg::NOTE_W-1:0]       e_note,
  input  logic [pva_pkg::LEVEL_W-1:0]      e_level,
  input  logic                             e_trk,
  input  logic [$clog2(NUM_VOICES)-1:0]    e_rank,
  input  pva_pkg::pva_cmd_t                cmd,
  input  logic [pva_pkg::NOTE_W-1:0]       req_note,
  input  logic [pva_pkg::FIN_W-1:0]        req_fin,
  input  logic                             steal_mode,
  output logic [$clog2(NUM_VOICES)-1:0]    sel_idx,
  output logic                             sel_stolen,
  output logic                             sel_retrig,
  output logic [pva_pkg::MASK_W-1:0]       rel_mask,
  output logic [$clog2(NUM_VOICES)-1:0]    hit_idx,
  output logic [$clog2(NUM_VOICES)-1:0]    new_rank,
  output logic [$clog2(NUM_VOICES)-1:0]    rem_rank,
  output pva_pkg::pva_upd_ctl_t            ctl
);
  import pva_pkg::*;

  localparam int VW = $clog2(NUM_VOICES);
  localparam int CW = $clog2(NUM_VOICES + 1);

  logic          match_vld_r, free_vld_r, vic_vld_r;
  logic [VW-1:0] match_idx_r, free_idx_r, vic_idx_r;
  logic          match_trk_r, free_trk_r;
  logic [VW-1:0] match_rank_r, free_rank_r, vic_rank_r;
  logic [LEVEL_W-1:0] vic_lvl_r;
  logic          v0_trk_r, fin_trk_r;
  logic [VW-1:0] v0_rank_r, fin_rank_r;
  logic [CW-1:0] len_r;
  logic [MASK_W-1:0] mask_r;

  logic note_hit, take_vic, fin_here, fin_valid, rel_hit;
  logic          sel_trk;
  logic [VW-1:0] sel_rank;

  assign note_hit  = e_act && (e_note == req_note);
  assign fin_here  = (32'(idx) == 32'(req_fin));
  assign fin_valid = (32'(req_fin) < NUM_VOICES);

  always_comb begin
    take_vic = 1'b0;
    if (e_trk) begin
      if (steal_mode == STEAL_OLDEST) begin
        take_vic = !vic_vld_r && (e_rank == '0);
      end else begin
        take_vic = (e_level < LEVEL_ONE) &&
                   (!vic_vld_r || (e_level < vic_lvl_r) ||
                    ((e_level == vic_lvl_r) && (e_rank < vic_rank_r)));
      end
    end
  end

  always_comb begin
    unique case (cmd)
      CMD_NOTE_OFF: rel_hit = note_hit;
      CMD_ALL_OFF:  rel_hit = e_act;
      default:      rel_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      match_vld_r <= 1'b0;
      free_vld_r  <= 1'b0;
      vic_vld_r   <= 1'b0;
      v0_trk_r    <= 1'b0;
      v0_rank_r   <= '0;
      fin_trk_r   <= 1'b0;
      fin_rank_r  <= '0;
      len_r       <= '0;
      mask_r      <= '0;
    end else if (en) begin
      if (!match_vld_r && note_hit) begin
        match_vld_r  <= 1'b1;
        match_idx_r  <= idx;
        match_trk_r  <= e_trk;
        match_rank_r <= e_rank;
      end
      if (!free_vld_r && !e_act) begin
        free_vld_r  <= 1'b1;
        free_idx_r  <= idx;
        free_trk_r  <= e_trk;
        free_rank_r <= e_rank;
      end
      if (take_vic) begin
        vic_vld_r  <= 1'b1;
        vic_idx_r  <= idx;
        vic_lvl_r  <= e_level;
        vic_rank_r <= e_rank;
      end
      if (idx == '0) begin
        v0_trk_r  <= e_trk;
        v0_rank_r <= e_rank;
      end
      if (fin_here) begin
        fin_trk_r  <= e_trk;
        fin_rank_r <= e_rank;
      end
      if (e_trk) begin
        len_r <= len_r + CW'(1);
      end
      if (rel_hit && (32'(idx) < MASK_W)) begin
        mask_r[4'(idx)] <= 1'b1;
      end
    end
  end

  // Note-on choice: same note first, then the lowest free voice, then a steal.
  always_comb begin
    priority if (match_vld_r) begin
      sel_idx  = match_idx_r;
      sel_trk  = match_trk_r;
      sel_rank = match_rank_r;
    end else if (free_vld_r) begin
      sel_idx  = free_idx_r;
      sel_trk  = free_trk_r;
      sel_rank = free_rank_r;
    end else if (vic_vld_r) begin
      sel_idx  = vic_idx_r;
      sel_trk  = 1'b1;
      sel_rank = vic_rank_r;
    end else begin
      sel_idx  = '0;
      sel_trk  = v0_trk_r;
      sel_rank = v0_rank_r;
    end
  end

  assign sel_stolen = !match_vld_r && !free_vld_r;
  assign sel_retrig = match_vld_r;
  assign rel_mask   = mask_r;
  assign new_rank   = VW'(len_r - CW'(sel_trk));

  always_comb begin
    ctl.write_note = (cmd == CMD_NOTE_ON);
    ctl.finish_hit = (cmd == CMD_VOICE_DONE) && fin_valid;
    ctl.clear_list = (cmd == CMD_ALL_OFF);
    if (cmd == CMD_NOTE_ON) begin
      ctl.remove_en = sel_trk;
      hit_idx       = sel_idx;
      rem_rank      = sel_rank;
    end else begin
      ctl.remove_en = ctl.finish_hit && fin_trk_r;
      hit_idx       = VW'(req_fin);
      rem_rank      = fin_rank_r;
    end
  end

endmodule

// ===== sv/pva_update.sv =====
// ---------------------------------------------------------------------------
// pva_update
// Rewrites one voice entry per cycle and counts the voices left active.
// ---------------------------------------------------------------------------
module pva_update #(
  parameter int NUM_VOICES = 16
) (
  input  logic                             clk,
  input  logic                             clr,
  input  logic                             en,
  input  logic [$clog2(NUM_VOICES)-1:0]    idx,
  input  logic                             e_act,
  input  logic [pva_pkg::NOTE_W-1:0]       e_note,
  input  logic [pva_pkg::LEVEL_W-1:0]      e_level,
  input  logic                             e_trk,
  input  logic [$clog2(NUM_VOICES)-1:0]    e_rank,
  input  pva_pkg::pva_upd_ctl_t            ctl,
  input  logic [$clog2(NUM_VOICES)-1:0]    hit_idx,
  input  logic [$clog2(NUM_VOICES)-1:0]    new_rank,
  input  logic [$clog2(NUM_VOICES)-1:0]    rem_rank,
  input  logic [pva_pkg::NOTE_W-1:0]       req_note,
  input  logic [pva_pkg::LEVEL_W-1:0]      req_level,
  output logic                             n_act,
  output logic [pva_pkg::NOTE_W-1:0]       n_note,
  output logic [pva_pkg::LEVEL_W-1:0]      n_level,
  output logic                             n_trk,
  output logic [$clog2(NUM_VOICES)-1:0]    n_rank,
  output logic [$clog2(NUM_VOICES+1)-1:0]  active_total
);
  import pva_pkg::*;

  localparam int VW = $clog2(NUM_VOICES);
  localparam int CW = $clog2(NUM_VOICES + 1);

  logic [CW-1:0] cnt_r;

  always_comb begin
    n_act   = e_act;
    n_note  = e_note;
    n_level = e_level;
    n_trk   = e_trk;
    n_rank  = e_rank;
    if (ctl.clear_list) begin
      n_trk  = 1'b0;
      n_rank = '0;
    end
    if (ctl.remove_en && e_trk && (e_rank > rem_rank)) begin
      n_rank = e_rank - VW'(1);
    end
    if (idx == hit_idx) begin
      if (ctl.write_note) begin
        n_act   = 1'b1;
        n_note  = req_note;
        n_level = req_level;
        n_trk   = 1'b1;
        n_rank  = new_rank;
      end else if (ctl.finish_hit) begin
        n_act  = 1'b0;
        n_trk  = 1'b0;
        n_rank = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr) begin
      cnt_r <= '0;
    end else if (en && n_act) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign active_total = cnt_r + CW'(en && n_act);

endmodule

// ===== sv/poly_voice_allocator.sv =====
// ---------------------------------------------------------------------------
// poly_voice_allocator
// Assigns note events to a pool of synth voices, with voice stealing.
// ---------------------------------------------------------------------------
//
//   Channel   Ports                               Handshake
//   --------  ----------------------------------  ---------------------------
//   request   start, busy, in_*                   taken when start && !busy
//   result    out_valid, out_*                    one-cycle strobe, no stall
//   config    psel, penable, pwrite, paddr,       APB rd/wr, pready always 1
//             pwdata, prdata, pready
//
// Each request keeps busy high through the SCAN, UPDATE and FLUSH states;
// the result strobe follows in the first cycle with busy low, so the block
// takes no new request before it is through with the last one. The pace
// is set by the single voice memory: a scan sweep reads one entry a cycle,
// and a rewrite sweep reads and writes back one entry a cycle.
// Reset is synchronous and active low. The memory is not cleared; one valid
// bit per entry makes an unwritten entry read as all zero, so the block takes
// requests right after reset. The result side cannot stall.
//
`include "poly_voice_allocator_defines.svh"

module poly_voice_allocator #(
  parameter int NUM_VOICES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              start,
  output logic                              busy,
  input  logic [pva_pkg::CMD_W-1:0]         in_command,
  input  logic [pva_pkg::NOTE_W-1:0]        in_note,
  input  logic [pva_pkg::LEVEL_W-1:0]       in_velocity,
  input  logic [pva_pkg::FIN_W-1:0]         in_finished_voice,
  // result channel
  output logic                              out_valid,
  output logic [pva_pkg::OUT_IDX_W-1:0]     out_voice_index,
  output logic                              out_stolen,
  output logic                              out_retriggered,
  output logic [pva_pkg::MASK_W-1:0]        out_released_mask,
  output logic [pva_pkg::OUT_CNT_W-1:0]     out_active_count,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pva_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pva_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pva_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import pva_pkg::*;

  localparam int VW = $clog2(NUM_VOICES);
  localparam int CW = $clog2(NUM_VOICES + 1);
  // Entry layout: {active, note, level, tracked, rank}.
  localparam int EW = 1 + NOTE_W + LEVEL_W + 1 + VW;

  // ------------------------------------------------------------------
  // Configuration register. Only the register index bit of the byte
  // address is decoded, so every address maps to register 0 or to the
  // empty slot above it.
  // ------------------------------------------------------------------
  logic steal_mode_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steal_mode_r <= STEAL_OLDEST;
    end else if (cfg_wr && (paddr[2] == REG_STEAL_MODE)) begin
      steal_mode_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_STEAL_MODE) ?
                  {{(CFG_DATA_W-1){1'b0}}, steal_mode_r} : '0;

  // ------------------------------------------------------------------
  // Sequencer. SCAN reads every entry once to gather the search; UPDATE
  // reads every entry again and writes each one back in the cycle after its
  // read; FLUSH writes back the last entry and loads the result.
  // ------------------------------------------------------------------
  pva_state_t state_r, state_nxt;
  logic [VW-1:0] cnt_r, cnt_nxt;
  logic          accept;
  logic          ram_re;
  logic [VW-1:0] ram_raddr;
  logic          last_idx;

  assign accept   = start && !busy;
  assign last_idx = (cnt_r == VW'(NUM_VOICES - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_SCAN;
      ST_SCAN:   if (last_idx) state_nxt = ST_UPDATE;
      ST_UPDATE: if (last_idx) state_nxt = ST_FLUSH;
      ST_FLUSH:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    ram_re    = 1'b0;
    ram_raddr = cnt_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        busy    = 1'b0;
        cnt_nxt = '0;
      end
      ST_SCAN, ST_UPDATE: begin
        ram_re  = 1'b1;
        cnt_nxt = last_idx ? '0 : cnt_r + VW'(1);
      end
      ST_FLUSH: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Request fields are held for the whole item.
  pva_cmd_t            cmd_r;
  logic [NOTE_W-1:0]   note_r;
  logic [LEVEL_W-1:0]  vel_r;
  logic [FIN_W-1:0]    fin_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= pva_cmd_t'(in_command);
      note_r <= in_note;
      vel_r  <= in_velocity;
      fin_r  <= in_finished_voice;
    end
  end

  // ------------------------------------------------------------------
  // Voice memory. Read data arrives in the cycle after the address, tagged
  // with its index and with the sweep it belongs to. During UPDATE the
  // write lags the read by one entry, so a read never meets a pending
  // write to the same entry and no forwarding is needed.
  // ------------------------------------------------------------------
  logic                  rd_vld_r, rd_upd_r;
  logic [VW-1:0]         rd_idx_r;
  logic [NUM_VOICES-1:0] valid_r;
  logic [EW-1:0]         ram_q, entry, wr_entry;
  logic                  ram_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      rd_upd_r <= 1'b0;
    end else begin
      rd_vld_r <= ram_re;
      rd_upd_r <= (state_r == ST_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= ram_raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ram_we) begin
      valid_r[rd_idx_r] <= 1'b1;
    end
  end

  assign ram_we = rd_vld_r && rd_upd_r;
  assign entry  = valid_r[rd_idx_r] ? ram_q : '0;

  pva_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_VOICES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_idx_r),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  logic               e_act, e_trk;
  logic [NOTE_W-1:0]  e_note;
  logic [LEVEL_W-1:0] e_level;
  logic [VW-1:0]      e_rank;

  assign {e_act, e_note, e_level, e_trk, e_rank} = entry;

  // ------------------------------------------------------------------
  // Search over the scan sweep and the decision that drives the rewrite.
  // ------------------------------------------------------------------
  logic [VW-1:0]     sel_idx, hit_idx, new_rank, rem_rank;
  logic              sel_stolen, sel_retrig;
  logic [MASK_W-1:0] rel_mask;
  pva_upd_ctl_t      upd_ctl;

  pva_scan #(
    .NUM_VOICES (NUM_VOICES)
  ) u_scan (
    .clk        (clk),
    .clr        (accept),
    .en         (rd_vld_r && !rd_upd_r),
    .idx        (rd_idx_r),
    .e_act      (e_act),
    .e_note     (e_note),
    .e_level    (e_level),
    .e_trk      (e_trk),
    .e_rank     (e_rank),
    .cmd        (cmd_r),
    .req_note   (note_r),
    .req_fin    (fin_r),
    .steal_mode (steal_mode_r),
    .sel_idx    (sel_idx),
    .sel_stolen (sel_stolen),
    .sel_retrig (sel_retrig),
    .rel_mask   (rel_mask),
    .hit_idx    (hit_idx),
    .new_rank   (new_rank),
    .rem_rank   (rem_rank),
    .ctl        (upd_ctl)
  );

  // ------------------------------------------------------------------
  // Rewrite of each entry and the count of active voices after the item.
  // ------------------------------------------------------------------
  logic               n_act, n_trk;
  logic [NOTE_W-1:0]  n_note;
  logic [LEVEL_W-1:0] n_level;
  logic [VW-1:0]      n_rank;
  logic [CW-1:0]      active_total;

  pva_update #(
    .NUM_VOICES (NUM_VOICES)
  ) u_update (
    .clk          (clk),
    .clr          (accept),
    .en           (ram_we),
    .idx          (rd_idx_r),
    .e_act        (e_act),
    .e_note       (e_note),
    .e_level      (e_level),
    .e_trk        (e_trk),
    .e_rank       (e_rank),
    .ctl          (upd_ctl),
    .hit_idx      (hit_idx),
    .new_rank     (new_rank),
    .rem_rank     (rem_rank),
    .req_note     (note_r),
    .req_level    (vel_r),
    .n_act        (n_act),
    .n_note       (n_note),
    .n_level      (n_level),
    .n_trk        (n_trk),
    .n_rank       (n_rank),
    .active_total (active_total)
  );

  assign wr_entry = {n_act, n_note, n_level, n_trk, n_rank};

  // ------------------------------------------------------------------
  // Result register. It loads at the end of FLUSH, when the last entry has
  // been rewritten and the active count is complete, and flags the result
  // with out_valid for the single following cycle.
  // ------------------------------------------------------------------
  logic                 out_valid_r;
  logic [OUT_IDX_W-1:0] out_voice_index_r;
  logic                 out_stolen_r, out_retriggered_r;
  logic [MASK_W-1:0]    out_released_mask_r;
  logic [OUT_CNT_W-1:0] out_active_count_r;
  logic                 finish;
  logic                 is_note_on;

  assign finish     = (state_r == ST_FLUSH);
  assign is_note_on = (cmd_r == CMD_NOTE_ON);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_voice_index_r   <= is_note_on ? OUT_IDX_W'(sel_idx) : '0;
      out_stolen_r        <= is_note_on && sel_stolen;
      out_retriggered_r   <= is_note_on && sel_retrig;
      out_released_mask_r <= rel_mask;
      out_active_count_r  <= OUT_CNT_W'(active_total);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_voice_index   = out_voice_index_r;
  assign out_stolen        = out_stolen_r;
  assign out_retriggered   = out_retriggered_r;
  assign out_released_mask = out_released_mask_r;
  assign out_active_count  = out_active_count_r;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  `PVA_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `PVA_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `PVA_ASSERT_IMPL(a_strobe_idle, clk, rst_n, out_valid, !busy)
  `PVA_ASSERT_IMPL(a_ram_no_overlap, clk, rst_n, ram_we && ram_re, rd_idx_r != ram_raddr)
  `PVA_ASSERT_IMPL(a_steal_xor_retrig, clk, rst_n, out_valid, !(out_stolen && out_retriggered))

endmodule
